### hdl/wsvm_pkg.sv
// Shared types, constants and constant tables for the wavetable voice mixer.
// Depends on nothing; used by every other file in hdl/.
`timescale 1ns / 1ps

package wsvm_pkg;

	// Build-time defaults
	localparam int VOICE_COUNT = 3;
	localparam int TABLE_LEN   = 512;
	localparam int RATE_HZ     = 44100;

	// Input kinds (s_tuser)
	localparam logic [1:0] MODE_TICK     = 2'd0;
	localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
	localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

	// Register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DETUNE  = 2'd3;

	localparam int ENV_W    = 17;
	localparam int GAIN_W   = 8;
	localparam int DETUNE_W = 12;
	localparam int COEF_W   = 16;
	localparam int SAW_W    = 16;
	localparam int FILT_W   = 18;
	localparam int DELTA_W  = 19;
	localparam int PHASE_W  = 32;

	localparam logic [ENV_W-1:0]    ATTACK_RST  = 17'd149;
	localparam logic [ENV_W-1:0]    RELEASE_RST = 17'd5;
	localparam logic [GAIN_W-1:0]   GAIN_RST    = 8'd90;
	localparam logic [DETUNE_W-1:0] DETUNE_RST  = 12'd459;

	localparam logic [ENV_W-1:0] ENV_ONE   = 17'd65536;
	localparam logic [ENV_W-1:0] ENV_QUIET = 17'd65;

	localparam int SAW_TOP  = 30000;
	localparam int SAW_SPAN = 60000;

	localparam logic [7:0] DAC_MID = 8'd128;
	localparam logic [7:0] DAC_MAX = 8'd255;
	localparam logic [7:0] DAC_MIN = 8'd0;

	// Shared multiplier operand / product widths
	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = 19;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int COEF_MIN = 3277;
	localparam int COEF_MAX = 58982;

	typedef logic [127:0][31:0]       pitch_rom_t;
	typedef logic [127:0][COEF_W-1:0] coef_rom_t;

	// Q16 Hz of notes 116..127
	localparam logic [11:0][31:0] TOP_OCTAVE = {
		32'd822074013, 32'd775934544, 32'd732384684, 32'd691279090,
		32'd652480576, 32'd615859655, 32'd581294109, 32'd548668578,
		32'd517874176, 32'd488808132, 32'd461373440, 32'd435478539
	};

	function automatic logic [31:0] note_hz_q16(input int n);
		int m;
		int sh;
		logic [31:0] v;
		m  = n + 4;
		sh = 10 - m / 12;
		v  = TOP_OCTAVE[m % 12];
		if (sh > 0) begin
			v = (v + (32'd1 << (sh - 1))) >> sh;
		end
		return v;
	endfunction

	function automatic pitch_rom_t make_pitch_rom();
		pitch_rom_t t;
		logic [63:0] hz;
		for (int n = 0; n < 128; n++) begin
			hz   = 64'(note_hz_q16(n));
			t[n] = 32'(((hz << 16) + 64'(RATE_HZ / 2)) / 64'(RATE_HZ));
		end
		return t;
	endfunction

	function automatic coef_rom_t make_coef_rom();
		coef_rom_t t;
		logic [63:0] c;
		for (int n = 0; n < 128; n++) begin
			c = (64'(note_hz_q16(n)) * 64'd16) / 64'(RATE_HZ);
			if (c < 64'(COEF_MIN)) begin
				c = 64'(COEF_MIN);
			end
			if (c > 64'(COEF_MAX)) begin
				c = 64'(COEF_MAX);
			end
			t[n] = COEF_W'(c);
		end
		return t;
	endfunction

	localparam pitch_rom_t PITCH_ROM = make_pitch_rom();
	localparam coef_rom_t  COEF_ROM  = make_coef_rom();

endpackage

### hdl/wavetable_synth_voice_mixer.sv
// Wavetable voice mixer top level: sequencer, voice state, envelope, mixer.
// Depends on wsvm_pkg, wsvm_ram (saw table) and wsvm_mul (shared multiplier).
`timescale 1ns / 1ps
// Usage
//   s_*   : input requests. s_tuser = mode (tick / note on / note off),
//           s_tdata = note number. Taken when s_tvalid && s_tready.
//   m_*   : one result per sample tick: DAC byte and gate flag. Note on,
//           note off and unused modes give no result.
//   cfg_* : register writes (index, data), always ready, any time idle.
// Sequence
//   Note on  : one detune multiply and add per voice, voice by voice.
//   Note off : applied on acceptance; the sequencer stays idle.
//   Tick     : envelope step and check, then the per-voice steps below through
//              the shared multiplier; straight to the result when quiet.
//   Per voice: phase add, index multiply, table read, delta, filter
//   multiply, accumulate; then envelope, gain and 1/VOICE_COUNT multiplies.
// Reset
//   arst_n low clears voices, envelope, gate and registers to defaults;
//   then the saw table is filled, one entry per cycle until all TABLE_LEN
//   entries are written, with s_tready low.
// Stall
//   A finished result sits in the output register and the next request is
//   still accepted; a second result waits in its last state for m_tready.

module wavetable_synth_voice_mixer #(
	parameter int VOICE_COUNT = wsvm_pkg::VOICE_COUNT,
	parameter int TABLE_LEN   = wsvm_pkg::TABLE_LEN
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [6:0] note_number, [7] zero
	input  logic [1:0]  s_tuser,    // [1:0] mode

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [7:0] dac_value, [8] note_active, [15:9] zero

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wsvm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wsvm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int IDX_W  = $clog2(TABLE_LEN);
	localparam int REM_W  = IDX_W + 1;
	localparam int SUM_W  = wsvm_pkg::FILT_W + $clog2(VOICE_COUNT);
	localparam int VDET_W = wsvm_pkg::DETUNE_W + $clog2(VOICE_COUNT);
	localparam int SAW_Q  = wsvm_pkg::SAW_SPAN / TABLE_LEN;
	localparam int SAW_R  = wsvm_pkg::SAW_SPAN % TABLE_LEN;
	// exact floor(t / VOICE_COUNT) for t < 2^RECIP_N
	localparam int RECIP_N = 14;
	localparam int RECIP_K = RECIP_N + $clog2(VOICE_COUNT);
	localparam int RECIP_M = ((1 << RECIP_K) + VOICE_COUNT - 1) / VOICE_COUNT;
	localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);
	localparam logic [IDX_W-1:0]  LAST_ENTRY = IDX_W'(TABLE_LEN - 1);

	typedef enum logic [16:0] {
		ST_FILL     = 17'b00000000000000001,
		ST_IDLE     = 17'b00000000000000010,
		ST_NOTE_MUL = 17'b00000000000000100,
		ST_NOTE_ADD = 17'b00000000000001000,
		ST_ENV      = 17'b00000000000010000,
		ST_CHK      = 17'b00000000000100000,
		ST_PHASE    = 17'b00000000001000000,
		ST_IDX      = 17'b00000000010000000,
		ST_ADDR     = 17'b00000000100000000,
		ST_DELTA    = 17'b00000001000000000,
		ST_FILT     = 17'b00000010000000000,
		ST_ACC      = 17'b00000100000000000,
		ST_MIX_ENV  = 17'b00001000000000000,
		ST_MIX_GAIN = 17'b00010000000000000,
		ST_MAG      = 17'b00100000000000000,
		ST_RECIP    = 17'b01000000000000000,
		ST_FIN      = 17'b10000000000000000
	} state_t;

	state_t state_q;

	// config registers
	logic [wsvm_pkg::ENV_W-1:0]    attack_q;
	logic [wsvm_pkg::ENV_W-1:0]    release_q;
	logic [wsvm_pkg::GAIN_W-1:0]   gain_q;
	logic [wsvm_pkg::DETUNE_W-1:0] detune_q;

	// voice state
	logic [wsvm_pkg::PHASE_W-1:0]       phase_q [VOICE_COUNT];
	logic [wsvm_pkg::PHASE_W-1:0]       step_q  [VOICE_COUNT];
	logic signed [wsvm_pkg::FILT_W-1:0] filt_q  [VOICE_COUNT];
	logic [wsvm_pkg::COEF_W-1:0]        coef_q;  // same for every voice
	logic [wsvm_pkg::ENV_W-1:0]         env_q;
	logic                               gate_q;

	// sequencer work registers
	logic [VIDX_W-1:0]                   v_q;
	logic [VDET_W-1:0]                   vdet_q;
	logic [wsvm_pkg::PHASE_W-1:0]        base_q;
	logic signed [wsvm_pkg::DELTA_W-1:0] delta_q;
	logic signed [SUM_W-1:0]             sum_q;
	logic                                neg_q;
	logic [RECIP_N-1:0]                  t_q;
	logic [7:0]                          dac_q;

	// saw table fill
	logic [IDX_W-1:0]                  fill_idx_q;
	logic signed [wsvm_pkg::SAW_W-1:0] fill_val_q;
	logic [REM_W-1:0]                  fill_rem_q;
	logic [REM_W-1:0]                  rem_sum;
	logic                              rem_wrap;

	// output register
	logic       out_valid_q;
	logic [7:0] out_dac_q;
	logic       out_gate_q;
	logic       out_free;

	// shared multiplier
	logic signed [wsvm_pkg::MUL_A_W-1:0] mul_a;
	logic signed [wsvm_pkg::MUL_B_W-1:0] mul_b;
	logic signed [wsvm_pkg::MUL_P_W-1:0] prod_q;

	// saw RAM
	logic                         ram_we;
	logic                         ram_re;
	logic [IDX_W-1:0]             ram_raddr;
	logic [wsvm_pkg::SAW_W-1:0]   ram_rdata;

	logic                              s_take;
	logic [wsvm_pkg::ENV_W:0]          env_sum;
	logic signed [wsvm_pkg::FILT_W-1:0] filt_new;
	logic [wsvm_pkg::MUL_P_W-1:0]      mag;
	logic [RECIP_N-1:0]                quot;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_take    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_gate_q, out_dac_q};

	assign rem_sum  = fill_rem_q + REM_W'(SAW_R);
	assign rem_wrap = (rem_sum >= REM_W'(TABLE_LEN));

	assign env_sum  = {1'b0, env_q} + {1'b0, attack_q};
	// floor(coef*delta/2^16), added modulo the filter width
	assign filt_new = wsvm_pkg::FILT_W'(filt_q[v_q] + $signed(prod_q[33:16]));
	assign mag      = prod_q[wsvm_pkg::MUL_P_W-1] ? wsvm_pkg::MUL_P_W'(-prod_q) : prod_q;
	assign quot     = prod_q[RECIP_K +: RECIP_N];

	assign ram_we    = (state_q == ST_FILL);
	assign ram_re    = (state_q == ST_ADDR);
	// floor(phase*(TABLE_LEN-1)/2^32), always below TABLE_LEN-1
	assign ram_raddr = prod_q[wsvm_pkg::PHASE_W +: IDX_W];

	wsvm_ram #(
		.WIDTH (wsvm_pkg::SAW_W),
		.DEPTH (TABLE_LEN)
	) u_saw (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_idx_q),
		.wdata (fill_val_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_NOTE_MUL: begin
				mul_a = wsvm_pkg::MUL_A_W'(base_q);
				mul_b = wsvm_pkg::MUL_B_W'(vdet_q);
			end
			ST_IDX: begin
				mul_a = wsvm_pkg::MUL_A_W'(phase_q[v_q]);
				mul_b = wsvm_pkg::MUL_B_W'(TABLE_LEN - 1);
			end
			ST_FILT: begin
				mul_a = wsvm_pkg::MUL_A_W'(delta_q);
				mul_b = wsvm_pkg::MUL_B_W'(coef_q);
			end
			ST_MIX_ENV: begin
				mul_a = wsvm_pkg::MUL_A_W'(sum_q);
				mul_b = wsvm_pkg::MUL_B_W'(env_q);
			end
			ST_MIX_GAIN: begin
				mul_a = prod_q[wsvm_pkg::MUL_A_W-1:0];
				mul_b = wsvm_pkg::MUL_B_W'(gain_q);
			end
			// kept through ST_FIN so the quotient survives an output stall
			ST_RECIP, ST_FIN: begin
				mul_a = wsvm_pkg::MUL_A_W'(t_q);
				mul_b = wsvm_pkg::MUL_B_W'(RECIP_M);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	wsvm_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod_q)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= wsvm_pkg::ATTACK_RST;
			release_q <= wsvm_pkg::RELEASE_RST;
			gain_q    <= wsvm_pkg::GAIN_RST;
			detune_q  <= wsvm_pkg::DETUNE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wsvm_pkg::REG_ATTACK:  attack_q  <= cfg_data[wsvm_pkg::ENV_W-1:0];
				wsvm_pkg::REG_RELEASE: release_q <= cfg_data[wsvm_pkg::ENV_W-1:0];
				wsvm_pkg::REG_GAIN:    gain_q    <= cfg_data[wsvm_pkg::GAIN_W-1:0];
				wsvm_pkg::REG_DETUNE:  detune_q  <= cfg_data[wsvm_pkg::DETUNE_W-1:0];
			endcase
		end
	end

	// sequencer and voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FILL;
			fill_idx_q <= '0;
			fill_val_q <= wsvm_pkg::SAW_W'(wsvm_pkg::SAW_TOP);
			fill_rem_q <= '0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				phase_q[i] <= '0;
				step_q[i]  <= '0;
				filt_q[i]  <= '0;
			end
			coef_q      <= '0;
			env_q       <= '0;
			gate_q      <= 1'b0;
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// ST_FIN sets the register itself when it is freed
			if (m_tvalid && m_tready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_FILL: begin
					// 30000 - floor(60000*i/TABLE_LEN), quotient/remainder stepped
					fill_idx_q <= fill_idx_q + 1'b1;
					if (rem_wrap) begin
						fill_rem_q <= rem_sum - REM_W'(TABLE_LEN);
						fill_val_q <= fill_val_q - wsvm_pkg::SAW_W'(SAW_Q + 1);
					end else begin
						fill_rem_q <= rem_sum;
						fill_val_q <= fill_val_q - wsvm_pkg::SAW_W'(SAW_Q);
					end
					if (fill_idx_q == LAST_ENTRY) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_take) begin
						unique case (s_tuser)
							wsvm_pkg::MODE_NOTE_ON: begin
								base_q  <= wsvm_pkg::PITCH_ROM[s_tdata[6:0]];
								coef_q  <= wsvm_pkg::COEF_ROM[s_tdata[6:0]];
								gate_q  <= 1'b1;
								v_q     <= '0;
								vdet_q  <= '0;
								state_q <= ST_NOTE_MUL;
							end
							wsvm_pkg::MODE_NOTE_OFF: begin
								gate_q <= 1'b0;
							end
							wsvm_pkg::MODE_TICK: begin
								state_q <= ST_ENV;
							end
							default: begin
								// unused mode: dropped
							end
						endcase
					end
				end
				ST_NOTE_MUL: begin
					state_q <= ST_NOTE_ADD;
				end
				ST_NOTE_ADD: begin
					step_q[v_q] <= base_q + prod_q[16 +: wsvm_pkg::PHASE_W];
					vdet_q      <= vdet_q + VDET_W'(detune_q);
					if (v_q == LAST_VOICE) begin
						state_q <= ST_IDLE;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= ST_NOTE_MUL;
					end
				end
				ST_ENV: begin
					if (gate_q) begin
						if (env_q < wsvm_pkg::ENV_ONE) begin
							env_q <= (env_sum > {1'b0, wsvm_pkg::ENV_ONE}) ?
								wsvm_pkg::ENV_ONE : env_sum[wsvm_pkg::ENV_W-1:0];
						end
					end else begin
						env_q <= (env_q > release_q) ? env_q - release_q : '0;
					end
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (env_q <= wsvm_pkg::ENV_QUIET) begin
						// quiet: phases and filters hold
						dac_q   <= wsvm_pkg::DAC_MID;
						state_q <= ST_FIN;
					end else begin
						v_q     <= '0;
						sum_q   <= '0;
						state_q <= ST_PHASE;
					end
				end
				ST_PHASE: begin
					phase_q[v_q] <= phase_q[v_q] + step_q[v_q];
					state_q      <= ST_IDX;
				end
				ST_IDX: begin
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					state_q <= ST_DELTA;
				end
				ST_DELTA: begin
					delta_q <= wsvm_pkg::DELTA_W'($signed(ram_rdata))
						- wsvm_pkg::DELTA_W'(filt_q[v_q]);
					state_q <= ST_FILT;
				end
				ST_FILT: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					filt_q[v_q] <= filt_new;
					sum_q       <= sum_q + SUM_W'(filt_new);
					if (v_q == LAST_VOICE) begin
						state_q <= ST_MIX_ENV;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= ST_PHASE;
					end
				end
				ST_MIX_ENV: begin
					state_q <= ST_MIX_GAIN;
				end
				ST_MIX_GAIN: begin
					state_q <= ST_MAG;
				end
				ST_MAG: begin
					// |total| / 2^31, then divide by VOICE_COUNT via reciprocal
					neg_q   <= prod_q[wsvm_pkg::MUL_P_W-1];
					t_q     <= mag[31 +: RECIP_N];
					state_q <= ST_RECIP;
				end
				ST_RECIP: begin
					dac_q   <= '0;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// dac_q is ready here on the quiet path; else built from quot
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_gate_q  <= gate_q;
						if (dac_q == wsvm_pkg::DAC_MID) begin
							out_dac_q <= wsvm_pkg::DAC_MID;
						end else if (neg_q) begin
							out_dac_q <= (quot >= RECIP_N'(128)) ? wsvm_pkg::DAC_MIN :
								8'(9'(wsvm_pkg::DAC_MID) - {2'b00, quot[6:0]});
						end else begin
							out_dac_q <= (quot >= RECIP_N'(127)) ? wsvm_pkg::DAC_MAX :
								{1'b1, quot[6:0]};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/wsvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on wsvm_pkg for default sizes.
`timescale 1ns / 1ps

module wsvm_ram #(
	parameter int WIDTH = wsvm_pkg::SAW_W,
	parameter int DEPTH = wsvm_pkg::TABLE_LEN
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/wsvm_mul.sv
// Shared signed multiplier with a registered product.
// Depends on wsvm_pkg for operand widths.
`timescale 1ns / 1ps

module wsvm_mul (
	input  logic                                 clk,
	input  logic signed [wsvm_pkg::MUL_A_W-1:0]  a,
	input  logic signed [wsvm_pkg::MUL_B_W-1:0]  b,
	output logic signed [wsvm_pkg::MUL_P_W-1:0]  prod
);

	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

### hdl/wsvm_checker.sv
// Port-level checks for the wavetable voice mixer, bound to the top level.
// Depends on wsvm_pkg and wavetable_synth_voice_mixer.
`timescale 1ns / 1ps

module wsvm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// tick and note-on requests keep the sequencer busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready &&
		(s_tuser == wsvm_pkg::MODE_TICK || s_tuser == wsvm_pkg::MODE_NOTE_ON)
		|=> !s_tready)
		else $error("ready right after a multi-cycle request");

	// a new result comes only out of a busy sequencer
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared from an idle sequencer");

endmodule

bind wavetable_synth_voice_mixer wsvm_checker u_wsvm_checker (.*);

### bench/wavetable_synth_voice_mixer_test.sv
// Self-checking bench for the wavetable voice mixer: directed and random
// requests against a cycle-free model of the voice, envelope and mixer.
// Depends on wsvm_pkg and the wavetable_synth_voice_mixer RTL only.
`timescale 1ns / 1ps

module wavetable_synth_voice_mixer_test;
	import wsvm_pkg::*;

	// Mode 3 has no name in the package; the block must drop it silently.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Cycles let pass after the last sample before a register write or the
	// end, long enough for a note on or a tick to finish.
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT   = 500000;

	// Q16 Hz of the top octave (notes 116..127); lower notes shift down.
	localparam longint unsigned TOP_HZ_Q16 [12] = '{
		435478539, 461373440, 488808132, 517874176,
		548668578, 581294109, 615859655, 652480576,
		691279090, 732384684, 775934544, 822074013
	};

	typedef struct packed {
		logic [7:0] dac;
		logic       gate;
	} dac_sample_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;     // [6:0] note_number, [7] zero
	logic [1:0]  s_tuser;     // [1:0] mode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;     // [7:0] dac_value, [8] note_active, [15:9] zero
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Expected DAC samples, oldest first; one per accepted tick.
	dac_sample_t pending_dac [$];
	int          errors;
	int          cycles;
	bit          in_idle;
	bit          out_idle;

	// Model tables
	logic signed [15:0] saw_wave [TABLE_LEN];
	logic [31:0]        note_inc [128];
	logic [15:0]        note_coef [128];

	// Model state and register copies
	logic [31:0]        voice_phase [VOICE_COUNT];
	logic [31:0]        voice_step [VOICE_COUNT];
	logic [15:0]        voice_coef [VOICE_COUNT];
	logic signed [17:0] voice_filt [VOICE_COUNT];
	logic [16:0]        envelope;
	logic               gate;
	logic [16:0]        atk_step;
	logic [16:0]        rel_step;
	logic [7:0]         mix_gain;
	logic [11:0]        detune;

	wavetable_synth_voice_mixer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Table contents and reset state of the model.
	initial begin : rom_setup
		longint unsigned hz;
		longint unsigned coef;
		int m;
		int sh;
		for (int i = 0; i < TABLE_LEN; i++) begin
			saw_wave[i] = 16'(SAW_TOP - (SAW_SPAN * i) / TABLE_LEN);
		end
		for (int n = 0; n < 128; n++) begin
			m  = n + 4;
			sh = 10 - m / 12;
			hz = TOP_HZ_Q16[m % 12];
			if (sh > 0) begin
				hz = (hz + (64'd1 << (sh - 1))) >> sh;
			end
			// Q32 turns per sample, rounded
			note_inc[n] = 32'(((hz << 16) + RATE_HZ / 2) / RATE_HZ);
			// Low-pass coefficient follows pitch, clamped to about 0.05..0.9
			coef = (hz * 16) / RATE_HZ;
			if (coef < COEF_MIN) begin
				coef = COEF_MIN;
			end
			if (coef > COEF_MAX) begin
				coef = COEF_MAX;
			end
			note_coef[n] = 16'(coef);
		end
		for (int v = 0; v < VOICE_COUNT; v++) begin
			voice_phase[v] = '0;
			voice_step[v]  = '0;
			voice_coef[v]  = '0;
			voice_filt[v]  = '0;
		end
		envelope = '0;
		gate     = 1'b0;
		atk_step = ATTACK_RST;
		rel_step = RELEASE_RST;
		mix_gain = GAIN_RST;
		detune   = DETUNE_RST;
	end

	// Applies one accepted request to the model; a tick queues its sample.
	task automatic voice_model_step(input logic [1:0] md, input logic [6:0] nt);
		logic [63:0] extra;
		logic [31:0] idx;
		int target;
		int env_next;
		int sum;
		int delta;
		longint prod;
		longint total;
		longint mag;
		longint dac;
		dac_sample_t res;
		case (md)
		MODE_NOTE_ON: begin
			// Voice v runs sharp by v * detune / 65536 of the base step
			for (int v = 0; v < VOICE_COUNT; v++) begin
				extra = (64'(note_inc[nt]) * 64'(v) * 64'(detune)) >> 16;
				voice_step[v] = note_inc[nt] + extra[31:0];
				voice_coef[v] = note_coef[nt];
			end
			gate = 1'b1;
		end
		MODE_NOTE_OFF: gate = 1'b0;
		MODE_TICK: begin
			// Linear envelope toward the gate target
			target   = gate ? int'(ENV_ONE) : 0;
			env_next = int'(envelope);
			if (env_next < target) begin
				env_next = env_next + int'(atk_step);
				if (env_next > target) begin
					env_next = target;
				end
			end else if (env_next > target) begin
				env_next = (env_next > int'(rel_step)) ? env_next - int'(rel_step) : 0;
			end
			envelope = 17'(env_next);
			res.gate = gate;
			res.dac  = DAC_MID;
			// Quiet envelope: silence, phases and filters frozen
			if (envelope > ENV_QUIET) begin
				sum = 0;
				for (int v = 0; v < VOICE_COUNT; v++) begin
					voice_phase[v] = voice_phase[v] + voice_step[v];
					idx   = 32'((64'(voice_phase[v]) * (TABLE_LEN - 1)) >> 32);
					delta = int'(saw_wave[idx]) - int'(voice_filt[v]);
					// Arithmetic shift floors negative products
					prod  = longint'(delta) * longint'(voice_coef[v]);
					voice_filt[v] = 18'(int'(voice_filt[v]) + int'(prod >>> 16));
					sum = sum + int'(voice_filt[v]);
				end
				total = longint'(sum) * longint'(envelope) * longint'(mix_gain);
				mag   = (total < 0) ? -total : total;
				mag   = mag / (longint'(VOICE_COUNT) <<< 31);
				dac   = ((total < 0) ? -mag : mag) + 128;
				if (dac < 0) begin
					dac = 0;
				end
				if (dac > 255) begin
					dac = 255;
				end
				res.dac = 8'(dac);
			end
			pending_dac.push_back(res);
		end
		default: ;
		endcase
	endtask

	// Stops sending, waits for the last sample, then lets the block settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_dac.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sends one request. tvalid stays high between back-to-back requests;
	// it is lowered only inside a random gap.
	task automatic send_item(input logic [1:0] md, input logic [6:0] nt);
		while (in_idle && $urandom_range(0, 99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= md;
		s_tdata  <= {1'b0, nt};
		do @(posedge clk); while (!s_tready);
		voice_model_step(md, nt);
	endtask

	// Writes all four registers once the block is idle.
	task automatic load_regs(input logic [16:0] atk, input logic [16:0] rel,
			input logic [7:0] gain, input logic [11:0] det);
		logic [CFG_IDX_W-1:0]  regs [4];
		logic [CFG_DATA_W-1:0] vals [4];
		regs = '{REG_ATTACK, REG_RELEASE, REG_GAIN, REG_DETUNE};
		vals = '{atk, rel, 17'(gain), 17'(det)};
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		atk_step = atk;
		rel_step = rel;
		mix_gain = gain;
		detune   = det;
	endtask

	// No note yet: ticks give silence whatever their note field; a note off
	// and an unused mode give nothing.
	task automatic test_idle_output();
		send_item(MODE_TICK, 7'h7f);
		send_item(MODE_TICK, 7'h00);
		send_item(MODE_UNUSED, 7'h55);
		send_item(MODE_NOTE_OFF, 7'h2a);
		send_item(MODE_TICK, 7'h3c);
	endtask

	// Lowest and highest note at reset settings.
	task automatic test_note_range();
		send_item(MODE_NOTE_ON, 7'd0);
		repeat (3) send_item(MODE_TICK, 7'h55);
		send_item(MODE_NOTE_ON, 7'd127);
		repeat (3) send_item(MODE_TICK, 7'h2a);
		send_item(MODE_NOTE_OFF, 7'd127);
		repeat (2) send_item(MODE_TICK, 7'd0);
	endtask

	// Zero attack holds the envelope where the last test left it; full attack
	// jumps to one and zero release holds it after note off. Maximum detune on the top note.
	task automatic test_step_extremes();
		load_regs(17'd0, 17'd0, 8'd255, 12'd4095);
		send_item(MODE_NOTE_ON, 7'd127);
		repeat (2) send_item(MODE_TICK, 7'd0);
		load_regs(17'd65536, 17'd0, 8'd255, 12'd4095);
		send_item(MODE_NOTE_ON, 7'd100);
		repeat (2) send_item(MODE_TICK, 7'd0);
		send_item(MODE_NOTE_OFF, 7'd0);
		send_item(MODE_TICK, 7'd0);
	endtask

	// Zero gain keeps mid scale even at full envelope; full release
	// drops to silence in one tick.
	task automatic test_gain_zero();
		load_regs(17'd65536, 17'd65536, 8'd0, 12'd0);
		send_item(MODE_NOTE_ON, 7'd64);
		send_item(MODE_TICK, 7'd0);
		send_item(MODE_NOTE_OFF, 7'd0);
		send_item(MODE_TICK, 7'd0);
	endtask

	// Mostly ticks after note ons, with note offs and unused modes mixed in.
	task automatic test_random_phase(input int count, input bit idling, input bit hold_mid);
		int pick;
		logic [1:0] md;
		in_idle  = idling;
		out_idle = idling;
		for (int k = 0; k < count; k++) begin
			// Let every sample drain once before going on
			if (hold_mid && k == count / 2) begin
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				md = MODE_TICK;
			end else if (pick < 82) begin
				md = MODE_NOTE_ON;
			end else if (pick < 94) begin
				md = MODE_NOTE_OFF;
			end else begin
				md = MODE_UNUSED;
			end
			send_item(md, 7'($urandom_range(0, 127)));
		end
		in_idle  = 1'b1;
		out_idle = 1'b1;
	endtask

	task automatic test_random_settings();
		load_regs(17'($urandom_range(1, 65536)), 17'($urandom_range(1, 65536)),
			8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
		test_random_phase(210, 1'b1, 1'b0);
		load_regs(17'd1, 17'd1, 8'd1, 12'd0);
		test_random_phase(210, 1'b1, 1'b1);
		load_regs(17'd65536, 17'd65536, 8'd255, 12'd4095);
		test_random_phase(210, 1'b1, 1'b0);
		// Long stretch at full rate on both sides
		load_regs(17'($urandom_range(1, 65536)), 17'($urandom_range(1, 65536)),
			8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
		test_random_phase(210, 1'b0, 1'b0);
		// Slow release keeps the voice sounding across many ticks
		load_regs(17'($urandom_range(1, 4000)), 17'($urandom_range(1, 300)),
			8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
		test_random_phase(210, 1'b1, 1'b0);
	endtask

	// Receiver: drops tready about one cycle in five unless told not to.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= !out_idle || ($urandom_range(0, 99) >= 20);
		end
	end

	// Compares each accepted sample with the oldest expected one.
	always @(posedge clk) begin : dac_check
		dac_sample_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_dac.size() == 0) begin
				$display("%0t: unexpected sample: expected none, actual dac %0d gate %0b",
					$time, m_tdata[7:0], m_tdata[8]);
				errors++;
			end else begin
				want = pending_dac.pop_front();
				if (m_tdata[7:0] !== want.dac) begin
					$display("%0t: dac_value: expected %0d, actual %0d",
						$time, want.dac, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[8] !== want.gate) begin
					$display("%0t: note_active: expected %0b, actual %0b",
						$time, want.gate, m_tdata[8]);
					errors++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		errors    = 0;
		in_idle   = 1'b1;
		out_idle  = 1'b1;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= MODE_TICK;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ATTACK;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n    <= 1'b1;
		// The saw table fill after reset holds s_tready low; the first
		// request simply waits for it.
		test_idle_output();
		test_note_range();
		test_step_extremes();
		test_gain_zero();
		test_random_settings();
		wait_drained();
		if (pending_dac.size() != 0) begin
			errors++;
		end
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
